/* sv/fcspm_pkg.sv */
package fcspm_pkg;

  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned PRESS_W = 14;
  localparam int unsigned VOLT_W  = 10;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam int unsigned PRESS_HOLD_TICKS = 30;
  localparam int unsigned VOLT_HOLD_TICKS  = 300;
  localparam int unsigned PRESS_CNT_W = $clog2(PRESS_HOLD_TICKS + 1);
  localparam int unsigned VOLT_CNT_W  = $clog2(VOLT_HOLD_TICKS + 2);

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_HIGH_ALARM = 3'd0,
    REG_TEMP_TRIP       = 3'd1,
    REG_TEMP_LOW_ALARM  = 3'd2,
    REG_TEMP_REC_LOW    = 3'd3,
    REG_TEMP_REC_HIGH   = 3'd4,
    REG_PRESS_OK        = 3'd5,
    REG_PRESS_LOW       = 3'd6,
    REG_VOLT_MIN        = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    VALVE_NONE  = 2'd0,
    VALVE_OPEN  = 2'd1,
    VALVE_CLOSE = 2'd2
  } valve_cmd_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_high_alarm_level;
    logic signed [TEMP_W-1:0] temp_trip_level;
    logic signed [TEMP_W-1:0] temp_low_alarm_level;
    logic signed [TEMP_W-1:0] temp_recover_low;
    logic signed [TEMP_W-1:0] temp_recover_high;
    logic [PRESS_W-1:0]       press_ok_level;
    logic [PRESS_W-1:0]       press_low_level;
    logic [VOLT_W-1:0]        volt_min_level;
  } cfg_levels_t;

endpackage

/* sv/fcspm_cfg_regs.sv */
module fcspm_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcspm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fcspm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output fcspm_pkg::cfg_levels_t            levels
);
  import fcspm_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      levels.temp_high_alarm_level <= 12'sd600;
      levels.temp_trip_level       <= 12'sd680;
      levels.temp_low_alarm_level  <= 12'sd150;
      levels.temp_recover_low      <= 12'sd200;
      levels.temp_recover_high     <= 12'sd500;
      levels.press_ok_level        <= 14'd300;
      levels.press_low_level       <= 14'd100;
      levels.volt_min_level        <= 10'd400;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_TEMP_HIGH_ALARM: levels.temp_high_alarm_level <= cfg_data[TEMP_W-1:0];
        REG_TEMP_TRIP:       levels.temp_trip_level       <= cfg_data[TEMP_W-1:0];
        REG_TEMP_LOW_ALARM:  levels.temp_low_alarm_level  <= cfg_data[TEMP_W-1:0];
        REG_TEMP_REC_LOW:    levels.temp_recover_low      <= cfg_data[TEMP_W-1:0];
        REG_TEMP_REC_HIGH:   levels.temp_recover_high     <= cfg_data[TEMP_W-1:0];
        REG_PRESS_OK:        levels.press_ok_level        <= cfg_data[PRESS_W-1:0];
        REG_PRESS_LOW:       levels.press_low_level       <= cfg_data[PRESS_W-1:0];
        REG_VOLT_MIN:        levels.volt_min_level        <= cfg_data[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/fuel_cell_stack_protection_monitor_unit.sv */
// channel   | dir | tdata / payload
// s_axis    | in  | cell_temp, hydrogen_press, stack_volt, stack_working
// m_axis    | out | four alarm flags, valve_cmd
// cfg       | in  | register index and level value
//
// one sample per cycle unless stalled: a sample is evaluated in the cycle it
// is accepted and its result sits in the output register on the next cycle
// the output register is the only stage; s_axis_tready drops only while a
// result is held and m_axis_tready is low
// rst (synchronous) restores the default levels and clears trips, counters
// and alarms
module fuel_cell_stack_protection_monitor_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [11:0] cell_temp, [25:12] hydrogen_press, [35:26] stack_volt,
  // [36] stack_working, [39:37] zero
  input  logic [fcspm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] temp_high_alarm, [1] temp_low_alarm, [2] press_low_alarm,
  // [3] volt_low_alarm, [5:4] valve_cmd, [7:6] zero
  output logic [fcspm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fcspm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcspm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fcspm_pkg::*;

  cfg_levels_t levels;

  logic signed [TEMP_W-1:0] t;
  logic [PRESS_W-1:0]       p;
  logic [VOLT_W-1:0]        v;
  logic                     working;
  logic                     accept;

  logic temp_tripped, temp_tripped_next;
  logic press_tripped, press_tripped_next;
  logic volt_tripped, volt_tripped_next;
  logic [PRESS_CNT_W-1:0] press_low_ticks, press_low_ticks_next;
  logic [VOLT_CNT_W-1:0]  volt_low_ticks, volt_low_ticks_next;
  logic [VOLT_CNT_W-1:0]  volt_good_ticks, volt_good_ticks_next;
  logic [3:0]             alarm_flags, alarm_flags_next;
  valve_cmd_t             valve;

  fcspm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .levels    (levels)
  );

  assign t       = s_axis_tdata[11:0];
  assign p       = s_axis_tdata[25:12];
  assign v       = s_axis_tdata[35:26];
  assign working = s_axis_tdata[36];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    temp_tripped_next    = temp_tripped;
    press_tripped_next   = press_tripped;
    volt_tripped_next    = volt_tripped;
    press_low_ticks_next = press_low_ticks;
    volt_low_ticks_next  = volt_low_ticks;
    volt_good_ticks_next = volt_good_ticks;
    alarm_flags_next     = alarm_flags;
    valve                = VALVE_NONE;

    // temperature
    if (t > levels.temp_high_alarm_level) begin
      alarm_flags_next[0] = 1'b1;
      if (t > levels.temp_trip_level && !temp_tripped) begin
        valve             = VALVE_CLOSE;
        temp_tripped_next = 1'b1;
      end
    end else if (t < levels.temp_low_alarm_level) begin
      alarm_flags_next[1] = 1'b1;
    end else begin
      if (t >= levels.temp_recover_low && t <= levels.temp_recover_high) begin
        if (temp_tripped) begin
          valve             = VALVE_OPEN;
          temp_tripped_next = 1'b0;
        end
        alarm_flags_next[0] = 1'b0;
      end
      alarm_flags_next[1] = 1'b0;
    end

    // pressure
    if (p >= levels.press_ok_level) begin
      alarm_flags_next[2] = 1'b0;
      if (press_tripped) begin
        valve              = VALVE_OPEN;
        press_tripped_next = 1'b0;
      end
    end else if (p >= levels.press_low_level) begin
      press_low_ticks_next = '0;
    end else begin
      alarm_flags_next[2] = 1'b1;
      if (press_low_ticks == PRESS_CNT_W'(PRESS_HOLD_TICKS - 1)) begin
        valve                = VALVE_CLOSE;
        press_tripped_next   = 1'b1;
        press_low_ticks_next = '0;
      end else begin
        press_low_ticks_next = press_low_ticks + 1'b1;
      end
    end

    // voltage, only while working
    if (working) begin
      if (v >= levels.volt_min_level) begin
        volt_low_ticks_next = '0;
        alarm_flags_next[3] = 1'b0;
        if (volt_tripped) begin
          if (volt_good_ticks >= VOLT_CNT_W'(VOLT_HOLD_TICKS - 1)) begin
            valve                = VALVE_OPEN;
            volt_tripped_next    = 1'b0;
            volt_good_ticks_next = '0;
          end else begin
            volt_good_ticks_next = volt_good_ticks + 1'b1;
          end
        end
      end else begin
        if (volt_low_ticks >= VOLT_CNT_W'(VOLT_HOLD_TICKS)) begin
          alarm_flags_next[3] = 1'b1;
          volt_tripped_next   = 1'b1;
          valve               = VALVE_CLOSE;
          volt_low_ticks_next = '0;
        end else begin
          volt_low_ticks_next = volt_low_ticks + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_tripped    <= 1'b0;
      press_tripped   <= 1'b0;
      volt_tripped    <= 1'b0;
      press_low_ticks <= '0;
      volt_low_ticks  <= '0;
      volt_good_ticks <= '0;
      alarm_flags     <= '0;
      m_axis_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        temp_tripped    <= temp_tripped_next;
        press_tripped   <= press_tripped_next;
        volt_tripped    <= volt_tripped_next;
        press_low_ticks <= press_low_ticks_next;
        volt_low_ticks  <= volt_low_ticks_next;
        volt_good_ticks <= volt_good_ticks_next;
        alarm_flags     <= alarm_flags_next;
        m_axis_tvalid   <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {2'b00, valve, alarm_flags_next};
    end
  end

endmodule

/* tb/fuel_cell_stack_protection_monitor_unit_tb.sv */
`timescale 1ns / 1ps

module fuel_cell_stack_protection_monitor_unit_tb;
  import fcspm_pkg::*;

  localparam int STALL_LIMIT     = 5000;
  localparam int N_PHASES        = 6;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int LONG_HOLD       = 300;
  localparam int N_DIRECTED      = 23;

  typedef struct packed {
    valve_cmd_t valve;
    logic       volt_low;
    logic       press_low;
    logic       temp_low;
    logic       temp_high;
  } monitor_status_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp;
    logic [PRESS_W-1:0] press;
    logic [VOLT_W-1:0]  volt;
    logic               working;
    logic               typed;
    monitor_status_t    status;
  } directed_row_t;

  // expected status typed in only where it is obvious
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    '{12'd300, 14'd500, 10'd500, 1'b1, 1'b1, '0},
    '{12'h7FF, 14'd500, 10'd500, 1'b1, 1'b1, '{VALVE_CLOSE, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{12'd681, 14'd500, 10'd500, 1'b1, 1'b1, '{VALVE_NONE, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{12'd640, 14'd500, 10'd500, 1'b1, 1'b0, '0},
    '{12'd600, 14'd500, 10'd500, 1'b1, 1'b0, '0},
    '{12'd500, 14'd500, 10'd500, 1'b1, 1'b0, '0},
    '{12'h800, 14'd500, 10'd500, 1'b1, 1'b1, '{VALVE_NONE, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{12'd150, 14'd500, 10'd500, 1'b1, 1'b0, '0},
    '{12'd200, 14'd500, 10'd500, 1'b1, 1'b0, '0},
    '{12'd300, 14'd0, 10'd500, 1'b1, 1'b1, '{VALVE_NONE, 1'b0, 1'b1, 1'b0, 1'b0}},
    '{12'd300, 14'd99, 10'd500, 1'b1, 1'b0, '0},
    '{12'd300, 14'd100, 10'd500, 1'b1, 1'b0, '0},
    '{12'd300, 14'd299, 10'd500, 1'b1, 1'b0, '0},
    '{12'd300, 14'd300, 10'd500, 1'b1, 1'b0, '0},
    '{12'd300, 14'h3FFF, 10'd500, 1'b1, 1'b1, '0},
    '{12'd300, 14'd500, 10'd0, 1'b0, 1'b0, '0},
    '{12'd300, 14'd500, 10'd0, 1'b1, 1'b0, '0},
    '{12'd300, 14'd500, 10'd399, 1'b1, 1'b0, '0},
    '{12'd300, 14'd500, 10'd400, 1'b1, 1'b0, '0},
    '{12'd300, 14'd500, 10'h3FF, 1'b1, 1'b1, '0},
    '{12'h7FF, 14'd0, 10'd0, 1'b0, 1'b0, '0},
    '{12'h800, 14'd5000, 10'h3FF, 1'b1, 1'b0, '0},
    '{12'd350, 14'd500, 10'd500, 1'b1, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TEMP_HIGH_ALARM;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state
  cfg_levels_t         levels;
  monitor_status_t     alarm;
  logic                temp_tripped;
  logic                press_tripped;
  logic                volt_tripped;
  logic [4:0]          press_low_ticks;
  logic [8:0]          volt_low_ticks;
  logic [8:0]          volt_good_ticks;

  monitor_status_t     due_status_q[$];
  monitor_status_t     got_status;
  monitor_status_t     want_status;
  monitor_status_t     tick_status;

  logic                sample_typed = 1'b0;
  monitor_status_t     sample_status = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;

  int n_samples = 0;
  int n_results = 0;
  int n_mismatch = 0;
  int n_close = 0;
  int n_open = 0;
  int n_press_trips = 0;
  int n_volt_trips = 0;
  int n_settings = 0;

  fuel_cell_stack_protection_monitor_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic advance_protection(input logic [TEMP_W-1:0] temp_raw,
                                    input logic [PRESS_W-1:0] press,
                                    input logic [VOLT_W-1:0] volt,
                                    input logic working,
                                    output monitor_status_t st);
    int t;
    valve_cmd_t valve;
    t = $signed(temp_raw);
    valve = VALVE_NONE;

    if (t > $signed(levels.temp_high_alarm_level)) begin
      alarm.temp_high = 1'b1;
      if (t > $signed(levels.temp_trip_level) && !temp_tripped) begin
        valve = VALVE_CLOSE;
        temp_tripped = 1'b1;
      end
    end else if (t < $signed(levels.temp_low_alarm_level)) begin
      alarm.temp_low = 1'b1;
    end else begin
      if (t >= $signed(levels.temp_recover_low) && t <= $signed(levels.temp_recover_high)) begin
        if (temp_tripped) begin
          valve = VALVE_OPEN;
          temp_tripped = 1'b0;
        end
        alarm.temp_high = 1'b0;
      end
      alarm.temp_low = 1'b0;
    end

    if (press >= levels.press_ok_level) begin
      alarm.press_low = 1'b0;
      if (press_tripped) begin
        valve = VALVE_OPEN;
        press_tripped = 1'b0;
      end
    end else if (press >= levels.press_low_level) begin
      press_low_ticks = '0;
    end else begin
      alarm.press_low = 1'b1;
      press_low_ticks = press_low_ticks + 5'd1;
      if (press_low_ticks >= PRESS_HOLD_TICKS) begin
        valve = VALVE_CLOSE;
        press_tripped = 1'b1;
        press_low_ticks = '0;
        n_press_trips++;
      end
    end

    // voltage state holds while the stack is not working
    if (working) begin
      if (volt >= levels.volt_min_level) begin
        volt_low_ticks = '0;
        alarm.volt_low = 1'b0;
        if (volt_tripped) begin
          volt_good_ticks = volt_good_ticks + 9'd1;
          if (volt_good_ticks >= VOLT_HOLD_TICKS) begin
            valve = VALVE_OPEN;
            volt_tripped = 1'b0;
            volt_good_ticks = '0;
          end
        end
      end else begin
        volt_low_ticks = volt_low_ticks + 9'd1;
        if (volt_low_ticks > VOLT_HOLD_TICKS) begin
          alarm.volt_low = 1'b1;
          volt_tripped = 1'b1;
          valve = VALVE_CLOSE;
          volt_low_ticks = '0;
          n_volt_trips++;
        end
      end
    end

    st = alarm;
    st.valve = valve;
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      n_mismatch++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // transaction monitor, predictor and watchdog
  always @(posedge clk) begin
    if (rst) begin
      levels = '{12'sd600, 12'sd680, 12'sd150, 12'sd200, 12'sd500, 14'd300, 14'd100, 10'd400};
      alarm = '0;
      temp_tripped = 1'b0;
      press_tripped = 1'b0;
      volt_tripped = 1'b0;
      press_low_ticks = '0;
      volt_low_ticks = '0;
      volt_good_ticks = '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status = monitor_status_t'(m_axis_tdata[5:0]);
        n_results++;
        if (due_status_q.size() == 0) begin
          n_mismatch++;
          $display("%0t: result with none expected, actual %b", $time, m_axis_tdata);
        end else begin
          want_status = due_status_q.pop_front();
          report_field("temp_high_alarm", want_status.temp_high, got_status.temp_high);
          report_field("temp_low_alarm", want_status.temp_low, got_status.temp_low);
          report_field("press_low_alarm", want_status.press_low, got_status.press_low);
          report_field("volt_low_alarm", want_status.volt_low, got_status.volt_low);
          report_field("valve_cmd", want_status.valve, got_status.valve);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_TEMP_HIGH_ALARM: levels.temp_high_alarm_level = cfg_data[TEMP_W-1:0];
          REG_TEMP_TRIP:       levels.temp_trip_level = cfg_data[TEMP_W-1:0];
          REG_TEMP_LOW_ALARM:  levels.temp_low_alarm_level = cfg_data[TEMP_W-1:0];
          REG_TEMP_REC_LOW:    levels.temp_recover_low = cfg_data[TEMP_W-1:0];
          REG_TEMP_REC_HIGH:   levels.temp_recover_high = cfg_data[TEMP_W-1:0];
          REG_PRESS_OK:        levels.press_ok_level = cfg_data[PRESS_W-1:0];
          REG_PRESS_LOW:       levels.press_low_level = cfg_data[PRESS_W-1:0];
          REG_VOLT_MIN:        levels.volt_min_level = cfg_data[VOLT_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_protection(s_axis_tdata[11:0], s_axis_tdata[25:12], s_axis_tdata[35:26],
                           s_axis_tdata[36], tick_status);
        n_samples++;
        if (tick_status.valve == VALVE_CLOSE) n_close++;
        if (tick_status.valve == VALVE_OPEN) n_open++;
        due_status_q.push_back(sample_typed ? sample_status : tick_status);
      end
    end

    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d cycles with no transaction", idle_cycles);
      $display("fuel_cell_stack_protection_monitor_unit: mismatch");
      $finish;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic drive_sample(input logic [TEMP_W-1:0] temp, input logic [PRESS_W-1:0] press,
                              input logic [VOLT_W-1:0] volt, input logic working,
                              input logic typed, input monitor_status_t st);
    s_axis_tdata <= {3'b000, working, volt, press, temp};
    s_axis_tvalid <= 1'b1;
    sample_typed <= typed;
    sample_status <= st;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic write_level(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (due_status_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] words [8];
    logic [TEMP_W-1:0]     gen_temp;
    logic [PRESS_W-1:0]    gen_press;
    logic [VOLT_W-1:0]     gen_volt;
    logic                  gen_working;
    int tlev [5];
    int hi, lo, rlo, plow, pok, vmin, base, r;
    int press_mode, press_run, volt_mode, volt_run;

    press_mode = 0;
    press_run = 0;
    volt_mode = 0;
    volt_run = 0;

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      drive_sample(DIRECTED[i].temp, DIRECTED[i].press, DIRECTED[i].volt,
                   DIRECTED[i].working, DIRECTED[i].typed, DIRECTED[i].status);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      drain_results();

      case (phase)
        1: begin
          for (int k = 0; k < 5; k++) words[k] = 14'(2000);
          words[5] = 14'd10000;
          words[6] = 14'd10000;
          words[7] = 14'd1000;
        end
        2: begin
          for (int k = 0; k < 5; k++) words[k] = 14'(-500);
          words[5] = '0;
          words[6] = '0;
          words[7] = '0;
        end
        3: begin
          for (int k = 0; k < 8; k++) words[k] = 14'($urandom);
        end
        5: begin
          words = '{14'd600, 14'd680, 14'd150, 14'd200, 14'd500, 14'd300, 14'd100, 14'd400};
        end
        default: begin
          hi = $urandom_range(300, 900);
          lo = $urandom_range(0, 300) - 100;
          rlo = lo + $urandom_range(0, 150);
          plow = $urandom_range(20, 400);
          pok = plow + $urandom_range(0, 400);
          vmin = $urandom_range(100, 900);
          words[0] = 14'(hi);
          words[1] = 14'(hi + $urandom_range(0, 200));
          words[2] = 14'(lo);
          words[3] = 14'(rlo);
          words[4] = 14'(rlo + $urandom_range(0, 300));
          words[5] = 14'(pok);
          words[6] = 14'(plow);
          words[7] = 14'(vmin);
        end
      endcase
      for (int k = 0; k < 8; k++) write_level(cfg_reg_t'(k), words[k]);
      cfg_valid <= 1'b0;
      @(negedge clk);
      n_settings++;

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase

      tlev[0] = $signed(levels.temp_high_alarm_level);
      tlev[1] = $signed(levels.temp_trip_level);
      tlev[2] = $signed(levels.temp_low_alarm_level);
      tlev[3] = $signed(levels.temp_recover_low);
      tlev[4] = $signed(levels.temp_recover_high);
      plow = levels.press_low_level;
      pok = levels.press_ok_level;
      vmin = levels.volt_min_level;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (phase == 1 && i == ITEMS_PER_PHASE / 2) drain_results();
        if (phase == 2 && i == 100) hold_req = 1'b1;

        r = $urandom_range(0, 99);
        if (r < 55) begin
          base = tlev[$urandom_range(0, 4)] + $urandom_range(0, 6) - 3;
        end else if (r < 90) begin
          base = $urandom_range(0, 2500) - 500;
        end else begin
          base = $urandom_range(0, 4095);
        end
        gen_temp = 12'(base);

        // pressure comes in runs so that low stretches reach the hold time
        if (press_run == 0) begin
          press_mode = $urandom_range(0, 9);
          press_run = (press_mode < 4) ? $urandom_range(20, 70) : $urandom_range(1, 20);
        end
        press_run--;
        if (press_mode < 4) begin
          base = (plow > 0) ? $urandom_range(0, plow - 1) : 0;
        end else if (press_mode < 6) begin
          base = (pok > plow) ? $urandom_range(plow, pok - 1) : plow;
        end else if (press_mode < 9) begin
          base = pok + $urandom_range(0, 200);
        end else begin
          base = $urandom_range(0, 16383);
        end
        gen_press = 14'(base);

        // voltage runs long enough to trip and to recover
        if (volt_run == 0) begin
          volt_mode = $urandom_range(0, 1);
          volt_run = volt_mode ? $urandom_range(100, 350) : $urandom_range(150, 450);
        end
        volt_run--;
        if (volt_mode == 0) begin
          base = (vmin > 0) ? $urandom_range(0, vmin - 1) : 0;
        end else if ($urandom_range(0, 19) == 0) begin
          base = $urandom_range(0, 1023);
        end else begin
          base = $urandom_range(vmin, 1023);
        end
        gen_volt = 10'(base);
        gen_working = ($urandom_range(0, 99) >= 8);

        while ($urandom_range(0, 99) < send_idle_pct) begin
          s_axis_tvalid <= 1'b0;
          @(negedge clk);
        end
        drive_sample(gen_temp, gen_press, gen_volt, gen_working, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(negedge clk);

    $display("%0d samples, %0d results checked over %0d level settings",
             n_samples, n_results, n_settings);
    $display("valve closes %0d, opens %0d, pressure trips %0d, voltage trips %0d",
             n_close, n_open, n_press_trips, n_volt_trips);
    if (n_mismatch == 0 && due_status_q.size() == 0) begin
      $display("fuel_cell_stack_protection_monitor_unit: match");
    end else begin
      $display("fuel_cell_stack_protection_monitor_unit: mismatch");
    end
    $finish;
  end

endmodule
